// File: hw/rtl/ccds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccds_pkg
// Shared types and constants for the C comment and directive stripper.
// ----------------------------------------------------------------------------
package ccds_pkg;

  localparam int unsigned MaxTextChars = 1048576;
  localparam int unsigned IdxW         = 20;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxTextChars - 1);

  // character codes
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChBSlash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef enum logic [2:0] {
    CtxCode      = 3'd0,
    CtxDirective = 3'd1,
    CtxLine      = 3'd2,
    CtxBlock     = 3'd3,
    CtxSQuote    = 3'd4,
    CtxDQuote    = 3'd5
  } ctx_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0]      kept_char;
    logic [IdxW-1:0] source_index;
    logic            char_valid;
    logic            end_of_text;
    logic            run_last;
  } res_t;

  // one queue entry: the results caused by one transaction
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } entry_t;

  typedef struct packed {
    logic keep;
    ctx_e ctx;
    logic esc;
    logic skip;
  } judge_t;

endpackage

// File: hw/rtl/ccds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccds_front
// Lexer front end: holds one character back, classifies it against the
// incoming one and pushes the results of each transaction into the queue.
// ----------------------------------------------------------------------------
module ccds_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ccds_pkg::item_t  item_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ccds_pkg::entry_t q_entry_o
);

  function automatic ccds_pkg::judge_t judge(ccds_pkg::ctx_e ctx, logic esc,
                                             logic [7:0] ch, logic [7:0] nxt);
    ccds_pkg::judge_t j;
    logic [7:0]       quote;
    j.keep = 1'b0;
    j.ctx  = ctx;
    j.esc  = esc;
    j.skip = 1'b0;
    quote  = (ctx == ccds_pkg::CtxSQuote) ? ccds_pkg::ChSQuote : ccds_pkg::ChDQuote;
    unique case (ctx)
      ccds_pkg::CtxDirective, ccds_pkg::CtxLine: begin
        if (ch == ccds_pkg::ChNl) begin
          j.ctx  = ccds_pkg::CtxCode;
          j.keep = 1'b1;
        end
      end
      ccds_pkg::CtxBlock: begin
        if (ch == ccds_pkg::ChStar && nxt == ccds_pkg::ChSlash) begin
          j.ctx  = ccds_pkg::CtxCode;
          j.skip = 1'b1;
        end
      end
      ccds_pkg::CtxSQuote, ccds_pkg::CtxDQuote: begin
        j.esc = (ch == ccds_pkg::ChBSlash) ? !esc : 1'b0;
        if (!j.esc && ch == quote) begin
          j.ctx  = ccds_pkg::CtxCode;
          j.keep = 1'b1;
        end
      end
      default: begin
        if (ch == ccds_pkg::ChHash) begin
          j.ctx = ccds_pkg::CtxDirective;
        end else if (ch == ccds_pkg::ChSlash && nxt == ccds_pkg::ChSlash) begin
          j.ctx = ccds_pkg::CtxLine;
        end else if (ch == ccds_pkg::ChSlash && nxt == ccds_pkg::ChStar) begin
          j.ctx = ccds_pkg::CtxBlock;
        end else begin
          j.keep = 1'b1;
          if (ch == ccds_pkg::ChDQuote) begin
            j.ctx = ccds_pkg::CtxDQuote;
          end else if (ch == ccds_pkg::ChSQuote) begin
            j.ctx = ccds_pkg::CtxSQuote;
          end else begin
            j.ctx = ccds_pkg::CtxCode;
          end
        end
      end
    endcase
    return j;
  endfunction

  ccds_pkg::ctx_e                ctx_q, ctx_d;
  logic                          esc_q, esc_d;
  logic                          skip_q, skip_d;
  logic                          held_valid_q, held_valid_d;
  logic [7:0]                    held_q;
  logic [ccds_pkg::IdxW-1:0]     pos_q;
  logic [ccds_pkg::IdxW-1:0]     cur_idx;
  logic                          accept;
  ccds_pkg::judge_t              j0, j1;
  logic                          keep0, keep1;
  ccds_pkg::res_t                r0, r1;

  assign accept = push_i && !q_full_i;

  always_comb begin
    if (!held_valid_q) begin
      cur_idx = '0;
    end else if (pos_q == ccds_pkg::LastIdx) begin
      cur_idx = '0;
    end else begin
      cur_idx = pos_q + ccds_pkg::IdxW'(1);
    end

    // judge the held character with the incoming one as lookahead
    j0     = judge(ctx_q, esc_q, held_q, item_i.in_char);
    ctx_d  = ctx_q;
    esc_d  = esc_q;
    skip_d = 1'b0;
    keep0  = 1'b0;
    if (held_valid_q && !skip_q) begin
      ctx_d  = j0.ctx;
      esc_d  = j0.esc;
      skip_d = j0.skip;
      keep0  = j0.keep;
    end

    // on the final character, judge it against a space
    j1    = judge(ctx_d, esc_d, item_i.in_char, ccds_pkg::ChSpace);
    keep1 = item_i.is_last && !skip_d && j1.keep;
    held_valid_d = !item_i.is_last;
  end

  always_comb begin
    r0 = '{kept_char: held_q, source_index: pos_q, char_valid: 1'b1,
           end_of_text: 1'b0, run_last: 1'b0};
    r1 = '{kept_char: item_i.in_char, source_index: cur_idx, char_valid: 1'b1,
           end_of_text: 1'b0, run_last: 1'b0};
    q_entry_o = '0;
    q_push_o  = 1'b0;
    if (!item_i.is_last) begin
      q_entry_o.first          = r0;
      q_entry_o.first.run_last = 1'b1;
      q_push_o                 = accept && keep0;
    end else begin
      q_push_o = accept;
      if (keep0 && keep1) begin
        q_entry_o.two                = 1'b1;
        q_entry_o.first              = r0;
        q_entry_o.second             = r1;
        q_entry_o.second.end_of_text = 1'b1;
        q_entry_o.second.run_last    = 1'b1;
      end else begin
        if (keep0) begin
          q_entry_o.first = r0;
        end else if (keep1) begin
          q_entry_o.first = r1;
        end
        q_entry_o.first.end_of_text = 1'b1;
        q_entry_o.first.run_last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q        <= ccds_pkg::CtxCode;
      esc_q        <= 1'b0;
      skip_q       <= 1'b0;
      held_valid_q <= 1'b0;
    end else if (accept) begin
      if (item_i.is_last) begin
        ctx_q  <= ccds_pkg::CtxCode;
        esc_q  <= 1'b0;
        skip_q <= 1'b0;
      end else begin
        ctx_q  <= ctx_d;
        esc_q  <= esc_d;
        skip_q <= skip_d;
      end
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= item_i.in_char;
      pos_q  <= cur_idx;
    end
  end

`ifndef SYNTHESIS
  // a skipped comment closer is always a held character
  a_skip_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> held_valid_q)
    else $error("skip flag set without a held character");
`endif

endmodule

// File: hw/rtl/ccds_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccds_fifo
// Short queue of result entries between the lexer and the output side.
// ----------------------------------------------------------------------------
module ccds_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  ccds_pkg::entry_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output ccds_pkg::entry_t rd_data_o,
  output logic             empty_o
);

  ccds_pkg::entry_t              mem_q [ccds_pkg::QDepth];
  logic [ccds_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [ccds_pkg::QPtrW:0]      cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o    = (cnt_q == (ccds_pkg::QPtrW + 1)'(ccds_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + (ccds_pkg::QPtrW + 1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - (ccds_pkg::QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + ccds_pkg::QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + ccds_pkg::QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("queue written while full");
  a_ptr_cnt_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != (ccds_pkg::QPtrW + 1)'(ccds_pkg::QDepth))
      |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// File: hw/rtl/ccds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccds_back
// Output side: presents the queued results one per transaction, splitting
// entries that carry two results.
// ----------------------------------------------------------------------------
module ccds_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  ccds_pkg::entry_t q_data_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ccds_pkg::res_t   result_o
);

  logic sel_q, sel_d;
  logic take;

  assign empty_o  = q_empty_i;
  assign result_o = sel_q ? q_data_i.second : q_data_i.first;
  assign take     = pop_i && !q_empty_i;
  assign q_pop_o  = take && (!q_data_i.two || sel_q);

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = q_data_i.two && !sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

`ifndef SYNTHESIS
  a_sel_on_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!q_empty_i && q_data_i.two))
    else $error("second slot selected without a paired entry");
`endif

endmodule

// File: hw/rtl/c_comment_and_directive_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_and_directive_stripper
// Streams C source text and passes on only code characters with their index.
// ----------------------------------------------------------------------------
// One character enters per transaction on the push/full side, and a new one
// can be taken every clock cycle. The lexer holds one character back so it
// can see the next, and judges the last character of a text against a space.
// Directive lines, line comments, block comments (closing star and slash
// included) and the insides of string and char literals are dropped; the
// newline ending a directive or line comment and the literal quotes are kept.
// Each transaction leaves zero, one or two results in a four-entry queue; the
// pop/empty side hands them out one per cycle, so an input that causes two
// results needs two pops. The final input of a text always causes at
// least one result, flagged end_of_text, and the lexer then starts afresh at
// index 0. A character's result is written into the queue at the edge that
// accepts the following character of the text (the final character's at its
// own edge), so it can be popped from the next edge on. The input stalls only
// while the queue holds four entries; a pop in the same cycle does not free a
// slot for that cycle.
// ----------------------------------------------------------------------------
module c_comment_and_directive_stripper (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input side
  input  logic            push,
  output logic            full,
  input  ccds_pkg::item_t item_i,
  // result side
  output logic            empty,
  input  logic            pop,
  output ccds_pkg::res_t  result_o
);

  // queue between lexer and output side
  logic             q_push;
  ccds_pkg::entry_t q_wr_entry;
  logic             q_full;
  logic             q_pop;
  ccds_pkg::entry_t q_rd_entry;
  logic             q_empty;

  assign full = q_full;

  // lexer: classifies characters and builds result entries
  ccds_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  ccds_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_push),
    .wr_data_i (q_wr_entry),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .rd_data_o (q_rd_entry),
    .empty_o   (q_empty)
  );

  // output side: one result per pop transaction
  ccds_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rd_entry),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

`ifndef SYNTHESIS
  // a result without a character only marks the end of a text
  a_blank_is_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.char_valid) |->
      (result_o.end_of_text && result_o.kept_char == 8'h00 &&
       result_o.source_index == '0))
    else $error("blank result that is not an end-of-text marker");
  // end of text is always the last result of its transaction
  a_eot_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.end_of_text) |-> result_o.run_last)
    else $error("end of text not marked as last of its run");
`endif

endmodule
